/* design/rlis_pkg.sv */
// ----------------------------------------------------------------------------
// rlis_pkg: shared types and constants of the RANSAC line inlier scorer
// Holds the action and status codes, the channel payloads and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rlis_pkg;

   // Actions carried by a request.
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_TEST  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // Status codes returned with every response.
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_RANGE  = 2'd2,
      STAT_REJECT = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam logic [0:0] CSR_RADIUS_SQ        = 1'd0;
   localparam logic [0:0] CSR_ALIGN_PERCENT_SQ = 1'd1;

   // Register reset values.
   localparam logic [31:0] RADIUS_SQ_RESET = 32'd812;
   localparam logic [6:0]  ALIGN_RESET     = 7'd81;

   // The alignment test compares against percent, so dx^2 is scaled by this.
   localparam logic [6:0]  ALIGN_SCALE     = 7'd100;

   typedef struct packed {
      action_type         action;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic [9:0]         index_a;
      logic [9:0]         index_b;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [10:0]        inlier_count;
      logic               became_best;
      logic [10:0]        best_count;
      logic [9:0]         best_index_a;
      logic [9:0]         best_index_b;
      logic signed [15:0] read_x;
      logic signed [15:0] read_y;
      logic signed [15:0] read_z;
      logic               is_inlier;
   } rsp_type;

endpackage

`default_nettype wire

/* design/rlis_if.sv */
// ----------------------------------------------------------------------------
// rlis_if: request and response channels of the line inlier scorer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlis_req_if;
   logic              valid;
   logic              ready;
   rlis_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rlis_rsp_if;
   logic              valid;
   logic              ready;
   rlis_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/rlis_ram.sv */
// ----------------------------------------------------------------------------
// rlis_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/ransac_line_inlier_scorer_top.sv */
// ----------------------------------------------------------------------------
// ransac_line_inlier_scorer_top: scores line hypotheses over a stored cloud
// Keeps a point cloud and two inlier flag banks in RAM, tests index pairs as
// lines and keeps the best line with its inlier flags.
//
//   Channel   Dir  Signals                         Transfer
//   req_ch    in   valid, ready, payload req_type  valid && ready
//   rsp_ch    out  valid, ready, payload rsp_type  valid && ready
//   csr       in   csr_we, csr_index, csr_wdata    csr_we
//
// A full test scans the whole cloud: the scan reads one stored point per
// cycle from the single read port of the point RAM into a seven-stage
// scoring pipeline. One request is in work at a time. Reset is
// synchronous; a finished response waits in the output register while the
// next request is accepted, and a stalled response holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ransac_line_inlier_scorer_top #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rlis_req_if.sink         req_ch,
   rlis_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int C    = COORD_BITS;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int IXW  = (CNTW > 10) ? CNTW : 10;  // index compare width
   localparam int DB   = C + 1;            // coordinate difference
   localparam int PB   = 2 * DB;           // cross-product term
   localparam int CB   = PB + 1;           // cross-product component
   localparam int H    = DB;               // half of a component magnitude
   localparam int MB   = 2 * H;            // component magnitude
   localparam int SQB  = 2 * MB;           // squared component
   localparam int LB   = SQB + 2;          // |(p-a) x d|^2
   localparam int DDB  = 2 * DB + 2;       // |d|^2
   localparam int DL   = (DDB + 1) / 2;
   localparam int DH   = DDB - DL;
   localparam int RB   = 32 + DDB;         // radius_sq * |d|^2
   localparam int CW   = (LB > RB) ? LB : RB;
   localparam int AB   = 2 * DB + 9;       // alignment compare

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_RDR, ST_RDB, ST_DIF, ST_SQ, ST_DD, ST_ALN,
      ST_RHS, ST_SCAN, ST_FIN, ST_DONE
   } state_type;

   state_type         state_ff;
   rlis_pkg::req_type cmd_ff;

   // Configuration registers.
   logic [31:0] radius_ff;
   logic [6:0]  align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= rlis_pkg::RADIUS_SQ_RESET;
         align_ff  <= rlis_pkg::ALIGN_RESET;
      end else if (csr_we) begin
         if (csr_index == rlis_pkg::CSR_RADIUS_SQ) begin
            radius_ff <= csr_wdata;
         end else if (csr_index == rlis_pkg::CSR_ALIGN_PERCENT_SQ) begin
            align_ff <= csr_wdata[6:0];
         end
      end
   end

   // Block state.
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] best_ff;
   logic            bank_ff;
   logic [9:0]      best_a_ff;
   logic [9:0]      best_b_ff;

   // Result under construction and output register.
   rlis_pkg::status_type status_ff;
   logic [CNTW-1:0]      icount_ff;
   logic                 became_ff;
   logic [C-1:0]         rd_ff [3];
   logic                 inl_ff;
   logic                 rsp_v_ff;
   rlis_pkg::rsp_type    rsp_ff;
   logic                 rsp_load;

   // Hypothesis setup.
   logic signed [C-1:0]  a_ff [3];
   logic signed [DB-1:0] d_ff [3];
   logic [2*DB-1:0]      dsq_ff [3];
   logic [DDB-1:0]       dd_ff;
   logic [2*DB-1:0]      dxs_ff;
   logic [32+DL-1:0]     rlo_ff;
   logic [32+DH-1:0]     rhi_ff;
   logic [RB-1:0]        rhs_ff;

   // Scan pipeline.
   logic [CNTW-1:0]      issue_ff;
   logic [CNTW-1:0]      scnt_ff;
   logic [7:1]           pv_ff;
   logic [AW-1:0]        idx_ff [1:7];
   logic signed [DB-1:0] q_ff [3];
   logic signed [PB-1:0] pr_ff [6];
   logic [MB-1:0]        cm_ff [3];
   logic [2*H-1:0]       pll_ff [3];
   logic [2*H-1:0]       phl_ff [3];
   logic [2*H-1:0]       phh_ff [3];
   logic [SQB-1:0]       sq_ff [3];
   logic                 flag_ff;

   // RAM ports.
   logic              pt_we;
   logic [AW-1:0]     pt_waddr;
   logic [3*C-1:0]    pt_wdata;
   logic [AW-1:0]     rd_addr;
   logic [3*C-1:0]    pt_rdata;
   logic [1:0]        fl_we;
   logic [AW-1:0]     fl_waddr;
   logic              fl_wdata;
   logic [1:0]        fl_rdata;

   rlis_ram #(.WIDTH(3 * C), .DEPTH(MAX_POINTS)) u_points (
      .clock (clock), .we (pt_we), .waddr (pt_waddr), .wdata (pt_wdata),
      .raddr (rd_addr), .rdata (pt_rdata)
   );

   rlis_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_flags0 (
      .clock (clock), .we (fl_we[0]), .waddr (fl_waddr), .wdata (fl_wdata),
      .raddr (rd_addr), .rdata (fl_rdata[0])
   );

   rlis_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_flags1 (
      .clock (clock), .we (fl_we[1]), .waddr (fl_waddr), .wdata (fl_wdata),
      .raddr (rd_addr), .rdata (fl_rdata[1])
   );

   // Decode of the captured request.
   logic            full;
   logic            ia_bad;
   logic            ib_bad;
   logic            iss_valid;
   logic            pipe_busy;
   logic            spare;

   always_comb begin
      full      = count_ff >= CNTW'(MAX_POINTS);
      ia_bad    = IXW'(cmd_ff.index_a) >= IXW'(count_ff);
      ib_bad    = IXW'(cmd_ff.index_b) >= IXW'(count_ff);
      iss_valid = (state_ff == ST_SCAN) && (issue_ff < count_ff);
      pipe_busy = |pv_ff;
      spare     = ~bank_ff;
   end

   // Memory port control.
   always_comb begin
      pt_we    = (state_ff == ST_EXEC) && (cmd_ff.action == rlis_pkg::ACT_LOAD) && !full;
      pt_waddr = AW'(count_ff);
      pt_wdata = {C'($unsigned(cmd_ff.coord_z)), C'($unsigned(cmd_ff.coord_y)),
                  C'($unsigned(cmd_ff.coord_x))};
      fl_we    = 2'b00;
      fl_waddr = idx_ff[7];
      fl_wdata = flag_ff;
      if (pt_we) begin
         fl_we    = 2'b11;
         fl_waddr = AW'(count_ff);
         fl_wdata = 1'b0;
      end else if (pv_ff[7]) begin
         fl_we[spare] = 1'b1;
      end
      case (state_ff)
         ST_EXEC: rd_addr = AW'(cmd_ff.index_a);
         ST_RDB:  rd_addr = AW'(cmd_ff.index_b);
         ST_SCAN: rd_addr = AW'(issue_ff);
         default: rd_addr = '0;
      endcase
   end

   // Setup arithmetic: direction component magnitudes and the alignment test.
   logic [DB-1:0] dmag [3];
   logic [AB-1:0] al_lhs;
   logic [AB-1:0] al_rhs;
   logic          reject;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dmag[k] = d_ff[k][DB-1] ? DB'(-d_ff[k]) : DB'(d_ff[k]);
      end
      al_lhs = AB'(dxs_ff) * AB'(rlis_pkg::ALIGN_SCALE);
      al_rhs = AB'(align_ff) * AB'(dd_ff);
      reject = (dd_ff == '0) || (al_lhs < al_rhs);
   end

   // Scan arithmetic per stage.
   logic signed [C-1:0]  pc [3];
   logic signed [CB-1:0] cv [3];
   logic [LB-1:0]        lhs;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pc[k] = signed'(pt_rdata[k*C +: C]);
      end
      cv[0] = CB'(pr_ff[0]) - CB'(pr_ff[1]);
      cv[1] = CB'(pr_ff[2]) - CB'(pr_ff[3]);
      cv[2] = CB'(pr_ff[4]) - CB'(pr_ff[5]);
      lhs   = LB'(sq_ff[0]) + LB'(sq_ff[1]) + LB'(sq_ff[2]);
   end

   // Scoring pipeline: difference, cross terms, magnitude, partial
   // products, squares, compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[6:1], iss_valid};
      end
      idx_ff[1] <= AW'(issue_ff);
      for (int s = 2; s <= 7; s++) begin
         idx_ff[s] <= idx_ff[s-1];
      end
      for (int k = 0; k < 3; k++) begin
         q_ff[k] <= DB'(pc[k]) - DB'(a_ff[k]);
      end
      pr_ff[0] <= PB'(q_ff[1]) * PB'(d_ff[2]);
      pr_ff[1] <= PB'(q_ff[2]) * PB'(d_ff[1]);
      pr_ff[2] <= PB'(q_ff[2]) * PB'(d_ff[0]);
      pr_ff[3] <= PB'(q_ff[0]) * PB'(d_ff[2]);
      pr_ff[4] <= PB'(q_ff[0]) * PB'(d_ff[1]);
      pr_ff[5] <= PB'(q_ff[1]) * PB'(d_ff[0]);
      for (int k = 0; k < 3; k++) begin
         cm_ff[k]  <= cv[k][CB-1] ? MB'(-cv[k]) : MB'(cv[k]);
         pll_ff[k] <= (2*H)'(cm_ff[k][H-1:0]) * (2*H)'(cm_ff[k][H-1:0]);
         phl_ff[k] <= (2*H)'(cm_ff[k][MB-1:H]) * (2*H)'(cm_ff[k][H-1:0]);
         phh_ff[k] <= (2*H)'(cm_ff[k][MB-1:H]) * (2*H)'(cm_ff[k][MB-1:H]);
         sq_ff[k]  <= SQB'(pll_ff[k]) + (SQB'(phl_ff[k]) << (H + 1))
                      + (SQB'(phh_ff[k]) << (2 * H));
      end
      flag_ff <= CW'(lhs) < CW'(rhs_ff);
   end

   // A finished result moves to the output register when that register is
   // free or is being emptied in the same cycle.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_v_ff || rsp_ch.ready);

   // Sequencer with state, block state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_v_ff  <= 1'b0;
         count_ff  <= '0;
         best_ff   <= '0;
         bank_ff   <= 1'b0;
         best_a_ff <= '0;
         best_b_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  cmd_ff    <= req_ch.payload;
                  status_ff <= rlis_pkg::STAT_OK;
                  icount_ff <= '0;
                  became_ff <= 1'b0;
                  inl_ff    <= 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     rd_ff[k] <= '0;
                  end
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (cmd_ff.action)
                  rlis_pkg::ACT_CLEAR: begin
                     count_ff  <= '0;
                     best_ff   <= '0;
                     bank_ff   <= 1'b0;
                     best_a_ff <= '0;
                     best_b_ff <= '0;
                     state_ff  <= ST_DONE;
                  end
                  rlis_pkg::ACT_LOAD: begin
                     if (full) begin
                        status_ff <= rlis_pkg::STAT_FULL;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                     end
                     state_ff <= ST_DONE;
                  end
                  rlis_pkg::ACT_TEST: begin
                     if (ia_bad || ib_bad) begin
                        status_ff <= rlis_pkg::STAT_RANGE;
                        state_ff  <= ST_DONE;
                     end else begin
                        state_ff <= ST_RDB;
                     end
                  end
                  default: begin
                     if (ia_bad) begin
                        status_ff <= rlis_pkg::STAT_RANGE;
                        state_ff  <= ST_DONE;
                     end else begin
                        state_ff <= ST_RDR;
                     end
                  end
               endcase
            end
            ST_RDR: begin
               for (int k = 0; k < 3; k++) begin
                  rd_ff[k] <= pt_rdata[k*C +: C];
               end
               inl_ff   <= (best_ff != '0) && fl_rdata[bank_ff];
               state_ff <= ST_DONE;
            end
            ST_RDB: begin
               for (int k = 0; k < 3; k++) begin
                  a_ff[k] <= pc[k];
               end
               state_ff <= ST_DIF;
            end
            ST_DIF: begin
               for (int k = 0; k < 3; k++) begin
                  d_ff[k] <= DB'(pc[k]) - DB'(a_ff[k]);
               end
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               for (int k = 0; k < 3; k++) begin
                  dsq_ff[k] <= (2*DB)'(dmag[k]) * (2*DB)'(dmag[k]);
               end
               state_ff <= ST_DD;
            end
            ST_DD: begin
               dd_ff    <= DDB'(dsq_ff[0]) + DDB'(dsq_ff[1]) + DDB'(dsq_ff[2]);
               dxs_ff   <= dsq_ff[0];
               state_ff <= ST_ALN;
            end
            ST_ALN: begin
               rlo_ff <= (32+DL)'(radius_ff) * (32+DL)'(dd_ff[DL-1:0]);
               rhi_ff <= (32+DH)'(radius_ff) * (32+DH)'(dd_ff[DDB-1:DL]);
               if (reject) begin
                  status_ff <= rlis_pkg::STAT_REJECT;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_RHS;
               end
            end
            ST_RHS: begin
               rhs_ff   <= RB'(rlo_ff) + (RB'(rhi_ff) << DL);
               issue_ff <= '0;
               scnt_ff  <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (iss_valid) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (pv_ff[7]) begin
                  scnt_ff <= scnt_ff + CNTW'(flag_ff);
               end
               if (!iss_valid && !pipe_busy) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               icount_ff <= scnt_ff;
               if (scnt_ff > best_ff) begin
                  best_ff   <= scnt_ff;
                  bank_ff   <= spare;
                  best_a_ff <= cmd_ff.index_a;
                  best_b_ff <= cmd_ff.index_b;
                  became_ff <= 1'b1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Response payload, loaded when the result leaves the sequencer.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.inlier_count <= 11'(icount_ff);
         rsp_ff.became_best  <= became_ff;
         rsp_ff.best_count   <= 11'(best_ff);
         rsp_ff.best_index_a <= best_a_ff;
         rsp_ff.best_index_b <= best_b_ff;
         rsp_ff.read_x       <= 16'($unsigned(rd_ff[0]));
         rsp_ff.read_y       <= 16'($unsigned(rd_ff[1]));
         rsp_ff.read_z       <= 16'($unsigned(rd_ff[2]));
         rsp_ff.is_inlier    <= inl_ff;
      end
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_v_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

`default_nettype wire

/* tb/rlis_checker.sv */
// ----------------------------------------------------------------------------
// rlis_checker: response predictor and scoreboard of the line inlier scorer
// Watches request and response transfers, keeps its own copy of the point
// cloud, the two flag banks, the best line and the registers, and compares
// every response field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module rlis_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  rlis_pkg::req_type    req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rlis_pkg::rsp_type    rsp_payload,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   error_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOUD_DEPTH = 1024;

   logic signed [15:0] cloud_x [CLOUD_DEPTH];
   logic signed [15:0] cloud_y [CLOUD_DEPTH];
   logic signed [15:0] cloud_z [CLOUD_DEPTH];
   logic               flag_bank [2][CLOUD_DEPTH];
   int unsigned        cloud_size;
   int unsigned        best_hits;
   logic               best_sel;
   logic [9:0]         best_a;
   logic [9:0]         best_b;
   logic [31:0]        radius_reg;
   logic [6:0]         align_reg;
   rlis_pkg::rsp_type  expected_rsps[$];

   assign pending = expected_rsps.size();

   // Scores one line into the given flag bank; returns -1 when rejected.
   function automatic int score_line(int unsigned ia, int unsigned ib, logic bank);
      logic signed [63:0]  dx, dy, dz, qx, qy, qz, cx, cy, cz;
      logic [63:0]         dd;
      logic [127:0]        rhs, lhs;
      int                  hits;
      dx = cloud_x[ib] - cloud_x[ia];
      dy = cloud_y[ib] - cloud_y[ia];
      dz = cloud_z[ib] - cloud_z[ia];
      dd = dx * dx + dy * dy + dz * dz;
      hits = 0;
      if (dd == 0) return -1;
      if (128'(100) * 128'(dx * dx) < 128'(align_reg) * 128'(dd)) return -1;
      rhs = 128'(radius_reg) * 128'(dd);
      for (int unsigned i = 0; i < cloud_size; i++) begin
         qx = cloud_x[i] - cloud_x[ia];
         qy = cloud_y[i] - cloud_y[ia];
         qz = cloud_z[i] - cloud_z[ia];
         cx = qy * dz - qz * dy;
         cy = qz * dx - qx * dz;
         cz = qx * dy - qy * dx;
         lhs = 128'($signed(128'(cx)) * $signed(128'(cx)))
             + 128'($signed(128'(cy)) * $signed(128'(cy)))
             + 128'($signed(128'(cz)) * $signed(128'(cz)));
         flag_bank[bank][i] = (lhs < rhs);
         hits += (lhs < rhs);
      end
      return hits;
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic rlis_pkg::rsp_type predict_response(rlis_pkg::req_type rq);
      rlis_pkg::rsp_type r;
      int      hits;
      logic    spare;
      r = '0;
      r.status = rlis_pkg::STAT_OK;
      case (rq.action)
         rlis_pkg::ACT_CLEAR: begin
            cloud_size = 0;
            best_hits = 0;
            best_sel = 0;
            best_a = 0;
            best_b = 0;
         end
         rlis_pkg::ACT_LOAD: begin
            if (cloud_size >= CLOUD_DEPTH) begin
               r.status = rlis_pkg::STAT_FULL;
            end else begin
               cloud_x[cloud_size] = rq.coord_x;
               cloud_y[cloud_size] = rq.coord_y;
               cloud_z[cloud_size] = rq.coord_z;
               flag_bank[0][cloud_size] = 0;
               flag_bank[1][cloud_size] = 0;
               cloud_size++;
            end
         end
         rlis_pkg::ACT_TEST: begin
            if (rq.index_a >= cloud_size || rq.index_b >= cloud_size) begin
               r.status = rlis_pkg::STAT_RANGE;
            end else begin
               spare = ~best_sel;
               hits = score_line(rq.index_a, rq.index_b, spare);
               if (hits < 0) begin
                  r.status = rlis_pkg::STAT_REJECT;
               end else begin
                  r.inlier_count = 11'(hits);
                  if (hits > best_hits) begin
                     best_hits = hits;
                     best_sel = spare;
                     best_a = rq.index_a;
                     best_b = rq.index_b;
                     r.became_best = 1'b1;
                  end
               end
            end
         end
         default: begin
            if (rq.index_a >= cloud_size) begin
               r.status = rlis_pkg::STAT_RANGE;
            end else begin
               r.read_x = cloud_x[rq.index_a];
               r.read_y = cloud_y[rq.index_a];
               r.read_z = cloud_z[rq.index_a];
               r.is_inlier = (best_hits > 0) ? flag_bank[best_sel][rq.index_a] : 1'b0;
            end
         end
      endcase
      r.best_count = 11'(best_hits);
      r.best_index_a = best_a;
      r.best_index_b = best_b;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Predict on request transfers, compare on response transfers.
   always @(posedge clock) begin
      rlis_pkg::rsp_type want;
      if (reset) begin
         cloud_size <= 0;
         best_hits <= 0;
         best_sel <= 0;
         best_a <= 0;
         best_b <= 0;
         radius_reg <= rlis_pkg::RADIUS_SQ_RESET;
         align_reg <= rlis_pkg::ALIGN_RESET;
         error_count <= 0;
         expected_rsps.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == rlis_pkg::CSR_RADIUS_SQ) radius_reg = csr_wdata;
            else align_reg = csr_wdata[6:0];
         end
         if (req_valid && req_ready)
            expected_rsps = {expected_rsps, predict_response(req_payload)};
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $realtime);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status != want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.inlier_count != want.inlier_count)
                  report_mismatch("inlier_count", rsp_payload.inlier_count, want.inlier_count);
               if (rsp_payload.became_best != want.became_best)
                  report_mismatch("became_best", rsp_payload.became_best, want.became_best);
               if (rsp_payload.best_count != want.best_count)
                  report_mismatch("best_count", rsp_payload.best_count, want.best_count);
               if (rsp_payload.best_index_a != want.best_index_a)
                  report_mismatch("best_index_a", rsp_payload.best_index_a, want.best_index_a);
               if (rsp_payload.best_index_b != want.best_index_b)
                  report_mismatch("best_index_b", rsp_payload.best_index_b, want.best_index_b);
               if (rsp_payload.read_x != want.read_x)
                  report_mismatch("read_x", rsp_payload.read_x, want.read_x);
               if (rsp_payload.read_y != want.read_y)
                  report_mismatch("read_y", rsp_payload.read_y, want.read_y);
               if (rsp_payload.read_z != want.read_z)
                  report_mismatch("read_z", rsp_payload.read_z, want.read_z);
               if (rsp_payload.is_inlier !== want.is_inlier)
                  report_mismatch("is_inlier", rsp_payload.is_inlier, want.is_inlier);
            end
         end
      end
   end
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the line inlier scorer
// Loads small point clouds clustered along x, tests random index pairs and
// reads points back under random sender gaps and receiver stalls, while the
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [0:0]  csr_index = rlis_pkg::CSR_RADIUS_SQ;
   logic [31:0] csr_wdata = '0;
   logic        hold_off = 0;
   logic        stall_on = 0;
   int          error_count;
   int          pending;
   int          idle_cycles = 0;
   int          sent = 0;
   int          tests_sent = 0;
   int          cloud_fill = 0;

   rlis_req_if req_ch ();
   rlis_rsp_if rsp_ch ();

   ransac_line_inlier_scorer_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rlis_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending(pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   // Receiver stalls on a pattern of its own, or holds off completely.
   always @(posedge clock) begin
      if (hold_off) rsp_ch.ready <= 0;
      else if (stall_on) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= 1;
   end

   // Stall pattern is switched on or off at random moments.
   always @(posedge clock) begin
      if ($urandom_range(0, 40) == 0) stall_on <= $urandom_range(0, 1);
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offers one request and waits for its transfer.
   task automatic send_request(rlis_pkg::req_type rq);
      req_ch.payload <= rq;
      req_ch.valid <= 1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (rq.action == rlis_pkg::ACT_TEST) tests_sent++;
      if (rq.action == rlis_pkg::ACT_LOAD && cloud_fill < 1024) cloud_fill++;
      if (rq.action == rlis_pkg::ACT_CLEAR) cloud_fill = 0;
      // Bursts: sometimes drop valid for a random gap.
      if ($urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic rlis_pkg::req_type make_req(rlis_pkg::action_type act, int x, int y,
                                                  int z, int a, int b);
      rlis_pkg::req_type rq;
      rq.action = act;
      rq.coord_x = 16'(x);
      rq.coord_y = 16'(y);
      rq.coord_z = 16'(z);
      rq.index_a = 10'(a);
      rq.index_b = 10'(b);
      return rq;
   endfunction

   // Lets the block drain before a register write or a pause.
   task automatic wait_drained();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Random point near a line along x, with occasional outliers.
   task automatic send_cloud_point();
      int x;
      x = $urandom_range(0, 4000) - 2000;
      if ($urandom_range(0, 4) == 0)
         send_request(make_req(rlis_pkg::ACT_LOAD, $urandom, $urandom, $urandom,
                               $urandom, $urandom));
      else
         send_request(make_req(rlis_pkg::ACT_LOAD, x, x / 8 + $urandom_range(0, 60) - 30,
                               $urandom_range(0, 60) - 30, $urandom, $urandom));
   endtask

   initial begin
      int n, a, b, roll;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty store, extremes, all actions, special cases.
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 1023, 0));
      send_request(make_req(rlis_pkg::ACT_LOAD, -32768, -32768, -32768, 0, 0));
      send_request(make_req(rlis_pkg::ACT_LOAD, 32767, 32767, 32767, 1023, 1023));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 1, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_LOAD, 32767, -32768, 32767, 0, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 0, 1));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 0, 2));
      send_request(make_req(rlis_pkg::ACT_LOAD, 0, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_LOAD, 100, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_LOAD, 50, 10, -10, 0, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 3, 4));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 4, 3));
      send_request(make_req(rlis_pkg::ACT_LOAD, 70, 1, 1, 0, 0));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 5, 0));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 4, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 3, 9));
      send_request(make_req(rlis_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 0, 0));

      // Load a batch of random points while the receiver holds off.
      wait_drained();
      write_reg(rlis_pkg::CSR_RADIUS_SQ, 32'hFFFF_FFFF);
      write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 7'd0);
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
      join_none
      for (int i = 0; i < 60; i++)
         send_request(make_req(rlis_pkg::ACT_LOAD, $urandom, $urandom, $urandom, 0, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 0, 1023));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 1023, 0));
      send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, 5, 6));
      send_request(make_req(rlis_pkg::ACT_READ, 0, 0, 0, 6, 0));
      send_request(make_req(rlis_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));

      // Random phases over small clouds, under several register settings.
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, 812);
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 81);
            end
            1: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, 0);
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 100);
            end
            2: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, 5000);
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 50);
            end
            3: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, $urandom);
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 0);
            end
            4: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, 32'hFFFF_FFFF);
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, 127);
            end
            default: begin
               write_reg(rlis_pkg::CSR_RADIUS_SQ, $urandom_range(100, 3000));
               write_reg(rlis_pkg::CSR_ALIGN_PERCENT_SQ, $urandom_range(60, 95));
            end
         endcase
         send_request(make_req(rlis_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
         n = $urandom_range(8, 40);
         for (int i = 0; i < n; i++) send_cloud_point();
         for (int i = 0; i < 60; i++) begin
            roll = $urandom_range(0, 19);
            a = $urandom_range(0, cloud_fill);
            b = $urandom_range(0, cloud_fill);
            if (roll < 11)
               send_request(make_req(rlis_pkg::ACT_TEST, $urandom, $urandom, $urandom, a, b));
            else if (roll < 17)
               send_request(make_req(rlis_pkg::ACT_READ, $urandom, $urandom, $urandom, a,
                                     $urandom));
            else if (roll < 19)
               send_cloud_point();
            else
               send_request(make_req(rlis_pkg::ACT_TEST, 0, 0, 0, $urandom, $urandom));
         end
      end

      // Drain and give the verdict.
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d requests, %0d line tests, out-of-range indexes,", sent,
               tests_sent);
      $display("six register settings and long response stalls.");
      if (error_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
